[sv/cvg_pkg.sv]
// ----------------------------------------------------------------------------
// cvg_pkg: shared types and constants for the CV/gate to note event block
// Field widths, register indexes, sequencer states and divider handshake.
// ----------------------------------------------------------------------------
`default_nettype none

package cvg_pkg;

	// Field and register widths
	localparam int PITCH_W   = 12;
	localparam int CFG_W     = 12;
	localparam int DEN_W     = 12;
	localparam int NOTE_W    = 7;
	localparam int CHAN_W    = 4;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 24;
	localparam int IDX_W     = 2;

	// Semitones in one volt of pitch input
	localparam int SEMIS_PER_VOLT = 12;

	localparam logic [NOTE_W-1:0] NOTE_MAX = 7'd127;
	localparam logic [NOTE_W-1:0] VEL_ON   = 7'd127;
	localparam logic [NOTE_W-1:0] VEL_OFF  = 7'd0;

	// Register reset values
	localparam logic [CFG_W-1:0]  ZERO_VOLT_RESET = 12'd0;
	localparam logic [CFG_W-1:0]  CPV_RESET       = 12'd819;
	localparam logic [NOTE_W-1:0] BASE_RESET      = 7'd60;
	localparam logic [CHAN_W-1:0] CHAN_RESET      = 4'd0;

	typedef logic [IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_ZERO_VOLT      = 2'd0;
	localparam cfg_idx_t REG_CODES_PER_VOLT = 2'd1;
	localparam cfg_idx_t REG_BASE_NOTE      = 2'd2;
	localparam cfg_idx_t REG_MIDI_CHANNEL   = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

[sv/cvg_div.sv]
// ----------------------------------------------------------------------------
// cvg_div: iterative unsigned restoring divider
// One quotient bit per cycle, DW quotient bits per division, done pulses once.
// ----------------------------------------------------------------------------
`default_nettype none

module cvg_div #(
	parameter int DW  = 16,
	parameter int DVW = 12
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire cvg_pkg::div_ctrl_t ctrl,
	input  wire  [DW-1:0]           dividend,
	input  wire  [DVW-1:0]          divisor,
	output cvg_pkg::div_stat_t      stat,
	output logic [DW-1:0]           quotient
);
	import cvg_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic [DVW-1:0] rem_q;
	logic [DW-1:0]  quo_q;
	logic [DVW-1:0] div_q;
	logic [CW-1:0]  cnt_q;
	logic           done_q;

	logic [DVW:0]   trial;
	logic           fits;
	logic [DVW:0]   diff;

	// Shift in the next dividend bit and try the subtract
	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		fits  = (trial >= {1'b0, div_q});
		diff  = trial - {1'b0, div_q};
	end

	// Step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (ctrl.start) begin
			cnt_q  <= CW'(DW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CW'(1);
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[DVW-1:0] : trial[DVW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

`default_nettype wire

[sv/cv_gate_to_note_events_top.sv]
// ----------------------------------------------------------------------------
// cv_gate_to_note_events_top: CV/gate samples to MIDI note events
// Emits note-on on a rising gate and note-off on a falling gate, with the
// pitch sample scaled to a rounded, clamped note number.
// ----------------------------------------------------------------------------
//
//  port group  | dir | beat content
//  ------------+-----+-------------------------------------------------------
//  s_*         | in  | tdata: gate[0], pitch[12:1], zero pad
//  m_*         | out | tdata: channel_out, note_number, velocity; tuser: note_on
//  cfg_*       | in  | write: zero-volt code, codes per volt, base note, channel
//
//  A sample with no gate change is accepted in the idle state and emits nothing.
//  A gate edge holds s_tready low through the PREP, DIV and FIN states; the
//  one-bit-per-cycle divider in cvg_div runs during DIV.
//  The result sits in an output register; the finish step waits only if that
//  register still holds an untaken beat.
//  Reset is asynchronous; config registers return to their defaults.
//
`default_nettype none

module cv_gate_to_note_events_top #(
	parameter int ADC_BITS = 12
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// gate [0], pitch [12:1], zero [15:13]
	input  wire  [cvg_pkg::S_TDATA_W-1:0]    s_tdata,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// channel_out [3:0], note_number [10:4], velocity [17:11], zero [23:18]
	output logic [cvg_pkg::M_TDATA_W-1:0]    m_tdata,
	// note_on [0]
	output logic [0:0]                       m_tuser,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	input  wire                              cfg_we,
	input  wire cvg_pkg::cfg_idx_t           cfg_index,
	input  wire  [cvg_pkg::CFG_W-1:0]        cfg_data
);
	import cvg_pkg::*;

	localparam int CODE_W = (ADC_BITS < PITCH_W) ? ADC_BITS : PITCH_W;
	localparam int MAG_W  = CODE_W + 4;
	localparam int DIVW   = (MAG_W > DEN_W + 1) ? MAG_W : DEN_W + 1;
	localparam int PAD_W  = M_TDATA_W - CHAN_W - 2 * NOTE_W;

	// Configuration registers
	logic [CFG_W-1:0]  zero_q;
	logic [CFG_W-1:0]  cpv_q;
	logic [NOTE_W-1:0] base_q;
	logic [CHAN_W-1:0] chan_q;

	state_t            state_q;
	state_t            state_d;
	logic              last_gate_q;
	logic [CODE_W-1:0] code_q;
	logic              gate_q;
	logic              neg_q;

	logic              out_valid_q;
	logic              out_on_q;
	logic [CHAN_W-1:0] out_chan_q;
	logic [NOTE_W-1:0] out_note_q;
	logic [NOTE_W-1:0] out_vel_q;

	logic              in_beat;
	logic              gate_flip;
	logic              out_free;
	logic              load_out;
	div_ctrl_t         div_ctrl;
	div_stat_t         div_stat;

	logic [CODE_W-1:0] zero_m;
	logic              delta_neg;
	logic [CODE_W-1:0] abs_delta;
	logic [MAG_W-1:0]  mag;
	logic [DEN_W-1:0]  den_eff;
	logic [DIVW-1:0]   dividend;
	logic [DIVW-1:0]   quo;
	logic [DIVW:0]     pos_sum;
	logic [NOTE_W-1:0] note_val;

	// Handshake decode
	assign s_tready  = (state_q == ST_IDLE);
	assign in_beat   = s_tvalid && s_tready;
	assign gate_flip = in_beat && (s_tdata[0] != last_gate_q);
	assign out_free  = !out_valid_q || m_tready;

	// Next state and sequencer strobes
	always_comb begin
		state_d        = state_q;
		div_ctrl.start = 1'b0;
		load_out       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (gate_flip) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				div_ctrl.start = 1'b1;
				state_d        = ST_DIV;
			end
			ST_DIV: begin
				if (div_stat.done && !div_stat.busy) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Config writes and gate history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q      <= ZERO_VOLT_RESET;
			cpv_q       <= CPV_RESET;
			base_q      <= BASE_RESET;
			chan_q      <= CHAN_RESET;
			last_gate_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ZERO_VOLT:      zero_q <= cfg_data;
					REG_CODES_PER_VOLT: cpv_q  <= cfg_data;
					REG_BASE_NOTE:      base_q <= cfg_data[NOTE_W-1:0];
					REG_MIDI_CHANNEL:   chan_q <= cfg_data[CHAN_W-1:0];
					default: ;
				endcase
			end
			if (in_beat) begin
				last_gate_q <= s_tdata[0];
			end
		end
	end

	// Signed offset from zero volts, scaled to semitones, plus half divisor
	always_comb begin
		zero_m    = zero_q[CODE_W-1:0];
		delta_neg = (code_q < zero_m);
		abs_delta = delta_neg ? (zero_m - code_q) : (code_q - zero_m);
		mag       = MAG_W'(abs_delta) * MAG_W'(SEMIS_PER_VOLT);
		den_eff   = (cpv_q == '0) ? DEN_W'(1) : cpv_q;
		dividend  = DIVW'(mag) + DIVW'(den_eff >> 1);
	end

	// Capture the sample and the sign of the offset
	always_ff @(posedge clk) begin
		if (in_beat) begin
			code_q <= s_tdata[CODE_W:1];
			gate_q <= s_tdata[0];
		end
		if (div_ctrl.start) begin
			neg_q <= delta_neg;
		end
	end

	cvg_div #(
		.DW  (DIVW),
		.DVW (DEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (dividend),
		.divisor  (den_eff),
		.stat     (div_stat),
		.quotient (quo)
	);

	// Apply sign, add base note, clamp to the note range
	always_comb begin
		pos_sum = (DIVW + 1)'(base_q) + (DIVW + 1)'(quo);
		if (neg_q) begin
			note_val = (quo > DIVW'(base_q)) ? '0 : (base_q - quo[NOTE_W-1:0]);
		end else begin
			note_val = (pos_sum > (DIVW + 1)'(NOTE_MAX)) ? NOTE_MAX : pos_sum[NOTE_W-1:0];
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_on_q   <= gate_q;
			out_chan_q <= chan_q;
			out_note_q <= note_val;
			out_vel_q  <= gate_q ? VEL_ON : VEL_OFF;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_vel_q, out_note_q, out_chan_q};
	assign m_tuser  = out_on_q;

endmodule

`default_nettype wire

[sv/cvg_checker.sv]
// ----------------------------------------------------------------------------
// cvg_checker: port-level checks for the CV/gate to note event block
// Watches handshakes and event ordering on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module cvg_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire [cvg_pkg::S_TDATA_W-1:0]  s_tdata,
	input wire                           s_tvalid,
	input wire                           s_tready,
	input wire [cvg_pkg::M_TDATA_W-1:0]  m_tdata,
	input wire [0:0]                     m_tuser,
	input wire                           m_tvalid,
	input wire                           m_tready
);
	import cvg_pkg::*;

	localparam int VEL_LO = CHAN_W + NOTE_W;

	logic gate_seen_q;
	logic last_kind_q;

	// Track the last accepted gate and the last delivered event kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_seen_q <= 1'b0;
			last_kind_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				gate_seen_q <= s_tdata[0];
			end
			if (m_tvalid && m_tready) begin
				last_kind_q <= m_tuser[0];
			end
		end
	end

	// Hold a stalled result beat
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// Velocity follows the event kind
	a_vel_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[0] ? (m_tdata[VEL_LO+NOTE_W-1:VEL_LO] == VEL_ON)
		                         : (m_tdata[VEL_LO+NOTE_W-1:VEL_LO] == VEL_OFF)))
		else $error("velocity does not match event kind");

	// A gate edge occupies the converter
	a_busy_after_edge: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tdata[0] != gate_seen_q) |=> !s_tready)
		else $error("input ready right after a gate edge");

	// Note-on and note-off alternate, starting with note-on
	a_kind_alternates: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |-> (m_tuser[0] != last_kind_q))
		else $error("two events of the same kind in a row");

endmodule

bind cv_gate_to_note_events_top cvg_checker u_cvg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tdata  (s_tdata),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

`default_nettype wire

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for cv_gate_to_note_events_top
// Streams gate/pitch samples through the block under several register
// settings. A tracker keeps its own copy of the registers and the last gate,
// predicts each note event and compares every output beat with it.
// ----------------------------------------------------------------------------

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cvg_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int SETTLE_LIMIT = 40;

	typedef struct packed {
		logic              note_on;
		logic [CHAN_W-1:0] channel;
		logic [NOTE_W-1:0] note;
		logic [NOTE_W-1:0] velocity;
	} note_event_t;

	// Predicts note events from accepted samples and checks output beats
	class note_event_tracker;
		logic [CFG_W-1:0]  zero_volt;
		logic [CFG_W-1:0]  cpv_reg;
		logic [NOTE_W-1:0] base_reg;
		logic [CHAN_W-1:0] channel;
		logic              last_gate;
		note_event_t       expected_events[$];
		int                errors;

		function new();
			zero_volt = ZERO_VOLT_RESET;
			cpv_reg   = CPV_RESET;
			base_reg  = BASE_RESET;
			channel   = CHAN_RESET;
			last_gate = 1'b0;
			errors    = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_ZERO_VOLT:      zero_volt = val;
				REG_CODES_PER_VOLT: cpv_reg   = val;
				REG_BASE_NOTE:      base_reg  = val[NOTE_W-1:0];
				REG_MIDI_CHANNEL:   channel   = val[CHAN_W-1:0];
				default: ;
			endcase
		endfunction

		// Scale pitch to semitones, round halves away from zero, clamp
		function logic [NOTE_W-1:0] predict_note(logic [PITCH_W-1:0] pitch);
			int delta, den, num, semis, sum;
			delta = int'(pitch) - int'(zero_volt);
			den   = (cpv_reg == 0) ? 1 : int'(cpv_reg);
			num   = delta * SEMIS_PER_VOLT;
			if (num >= 0) begin
				semis = (num + den / 2) / den;
			end else begin
				semis = -((-num + den / 2) / den);
			end
			sum = int'(base_reg) + semis;
			if (sum < 0) begin
				sum = 0;
			end
			if (sum > int'(NOTE_MAX)) begin
				sum = int'(NOTE_MAX);
			end
			return sum[NOTE_W-1:0];
		endfunction

		function void note_sample(logic gate, logic [PITCH_W-1:0] pitch);
			note_event_t ev;
			if (gate == last_gate) begin
				return;
			end
			ev.note_on  = gate;
			ev.channel  = channel;
			ev.note     = predict_note(pitch);
			ev.velocity = gate ? VEL_ON : VEL_OFF;
			expected_events.push_back(ev);
			last_gate = gate;
		endfunction

		function void check_event(logic [M_TDATA_W-1:0] data, logic user);
			note_event_t got, exp_ev;
			got.note_on  = user;
			got.channel  = data[3:0];
			got.note     = data[10:4];
			got.velocity = data[17:11];
			if (expected_events.size() == 0) begin
				errors++;
				$display("%0t: unexpected note event on=%0d ch=%0d note=%0d vel=%0d",
					$realtime, got.note_on, got.channel, got.note, got.velocity);
				return;
			end
			exp_ev = expected_events.pop_front();
			if (got !== exp_ev) begin
				errors++;
				$display("%0t: note event mismatch: expected on=%0d ch=%0d note=%0d vel=%0d, got on=%0d ch=%0d note=%0d vel=%0d",
					$realtime, exp_ev.note_on, exp_ev.channel, exp_ev.note, exp_ev.velocity,
					got.note_on, got.channel, got.note, got.velocity);
			end
		endfunction

		function int pending();
			return expected_events.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [0:0]            m_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic                  cfg_we;
	cfg_idx_t              cfg_index;
	logic [CFG_W-1:0]      cfg_data;

	note_event_tracker tracker;
	int                burst_left;
	int                ready_left;
	int                ready_mode;
	int                cycle_count;

	cv_gate_to_note_events_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Stall the output side: steady stretches of ready or stall, or jitter
	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_left = $urandom_range(1, 40);
			ready_mode = $urandom_range(0, 3);
		end else begin
			ready_left--;
		end
		case (ready_mode)
			0, 1:    m_tready <= 1'b1;
			2:       m_tready <= 1'b0;
			default: m_tready <= $urandom_range(0, 1);
		endcase
	end

	// Check each output beat against the oldest predicted event
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			tracker.check_event(m_tdata, m_tuser[0]);
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Send one sample; open a new burst after a random gap when one runs out
	task automatic send_sample(input logic gate, input logic [PITCH_W-1:0] pitch);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) :
				$urandom_range(1, 12);
		end
		burst_left--;
		s_tdata  <= {{(S_TDATA_W - PITCH_W - 1){1'b0}}, pitch, gate};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		tracker.note_sample(gate, pitch);
	endtask

	task automatic end_stream();
		s_tvalid   <= 1'b0;
		burst_left = 0;
	endtask

	// Wait for every predicted event, then let the block settle
	task automatic drain();
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_LIMIT) @(posedge clk);
	endtask

	// Write all four registers on consecutive cycles while the block is idle
	task automatic write_regs(input logic [CFG_W-1:0] zv, input logic [CFG_W-1:0] cpv,
		input logic [NOTE_W-1:0] base, input logic [CHAN_W-1:0] chan);
		cfg_idx_t         idx [4];
		logic [CFG_W-1:0] val [4];
		idx = '{REG_ZERO_VOLT, REG_CODES_PER_VOLT, REG_BASE_NOTE, REG_MIDI_CHANNEL};
		val = '{zv, cpv, {{(CFG_W - NOTE_W){1'b0}}, base}, {{(CFG_W - CHAN_W){1'b0}}, chan}};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			tracker.set_reg(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// Pick a register value, favoring the two ends of its range
	function automatic int pick_value(int hi);
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return hi;
			default: return $urandom_range(0, hi);
		endcase
	endfunction

	// Pitch: full range half the time, otherwise near the zero-volt code
	function automatic logic [PITCH_W-1:0] pick_pitch();
		int span, v;
		if ($urandom_range(0, 1) == 0) begin
			return PITCH_W'($urandom_range(0, 4095));
		end
		span = (tracker.cpv_reg == 0) ? 8 : int'(tracker.cpv_reg) * 6;
		v = int'(tracker.zero_volt) + int'($urandom_range(0, 2 * span)) - span;
		if (v < 0) begin
			v = 0;
		end
		if (v > 4095) begin
			v = 4095;
		end
		return v[PITCH_W-1:0];
	endfunction

	task automatic run_random(input int count);
		logic gate;
		int   toggle_pct;
		gate       = tracker.last_gate;
		toggle_pct = $urandom_range(20, 90);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < toggle_pct) begin
				gate = ~gate;
			end
			send_sample(gate, pick_pitch());
		end
		end_stream();
		drain();
	endtask

	initial begin
		tracker     = new();
		arst_n      <= 1'b0;
		s_tdata     <= '0;
		s_tvalid    <= 1'b0;
		m_tready    <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= REG_ZERO_VOLT;
		cfg_data    <= '0;
		cycle_count <= 0;
		burst_left  = 0;
		ready_left  = 0;
		ready_mode  = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: note at zero volts, then one volt up
		send_sample(1'b1, 12'd0);
		send_sample(1'b1, 12'd100);
		send_sample(1'b0, 12'd819);
		end_stream();
		drain();

		// Even divisor: exact halves round away from zero, clamp both ends
		write_regs(12'd2048, 12'd24, 7'd64, 4'd15);
		send_sample(1'b1, 12'd2049);
		send_sample(1'b0, 12'd2047);
		send_sample(1'b0, 12'd2047);
		send_sample(1'b1, 12'd0);
		send_sample(1'b0, 12'd4095);
		send_sample(1'b1, 12'd2048);
		end_stream();
		drain();

		// Zero divisor is taken as one; top base note
		write_regs(12'd4095, 12'd0, 7'd127, 4'd0);
		send_sample(1'b0, 12'd4095);
		send_sample(1'b1, 12'd4095);
		send_sample(1'b0, 12'd4094);
		send_sample(1'b1, 12'd0);
		end_stream();
		drain();

		// Widest odd divisor, base note zero
		write_regs(12'd0, 12'd4095, 7'd0, 4'd8);
		send_sample(1'b0, 12'd4095);
		send_sample(1'b1, 12'd4095);
		send_sample(1'b0, 12'd170);
		send_sample(1'b1, 12'd171);
		send_sample(1'b1, 12'd2730);
		send_sample(1'b0, 12'd2730);
		end_stream();
		drain();

		// Random phases, each under its own register setting
		for (int phase = 0; phase < 8; phase++) begin
			write_regs(CFG_W'(pick_value(4095)),
				($urandom_range(0, 2) == 0) ? CFG_W'(pick_value(4095)) :
					CFG_W'($urandom_range(100, 1000)),
				NOTE_W'(pick_value(127)), CHAN_W'(pick_value(15)));
			run_random(190);
		end

		if (tracker.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[cv_gate_to_note_events_top.f]
sv/cvg_pkg.sv
sv/cvg_div.sv
sv/cv_gate_to_note_events_top.sv
sv/cvg_checker.sv
bench/tb_top.sv
